>>> rtl/core/lprp_pkg.sv
package lprp_pkg;

    // argument limit after reset
    localparam logic [31:0] MAX_ARGS_RESET = 32'd1024;

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_COUNT   = 4'b0001,
        PH_LENGTH  = 4'b0010,
        PH_DATA    = 4'b0100,
        PH_DISCARD = 4'b1000
    } t_phase;

    // tag given to each byte
    typedef enum logic [1:0] {
        KIND_COUNT   = 2'd0,
        KIND_LENGTH  = 2'd1,
        KIND_DATA    = 2'd2,
        KIND_DISCARD = 2'd3
    } t_kind;

    // verdict codes, also used as the latched error (pending means none)
    typedef enum logic [2:0] {
        VERD_PENDING   = 3'd0,
        VERD_ACCEPTED  = 3'd1,
        VERD_TRUNCATED = 3'd2,
        VERD_TOO_MANY  = 3'd3,
        VERD_TRAILING  = 3'd4
    } t_verdict;

    // one result item
    typedef struct packed {
        t_kind       byte_kind;
        logic [7:0]  data_out;
        logic [31:0] arg_index;
        logic        arg_done;
        t_verdict    verdict;
    } t_result;

endpackage

>>> rtl/core/length_prefixed_request_parser_core.sv
// channel   | handshake                  | payload
// ----------+----------------------------+------------------------------------------
// input     | i_in_valid / o_in_ready    | i_payload_byte, i_message_end
// result    | o_out_valid / i_out_ready  | o_byte_kind, o_data_out, o_arg_index,
//           |                            | o_arg_done, o_verdict
// config    | i_cfg_we (no wait)         | i_cfg_wdata (max_arguments)
//
// one byte per cycle sustained while i_out_ready holds; an accepted byte goes into the input
// register, then through the parse logic into the output register
// synchronous active-low reset clears parse state, both valid flags, and sets
// max_arguments to 1024
// a stalled result holds the output register; the input register keeps filling
// until both stages are full, then o_in_ready drops
module length_prefixed_request_parser_core import lprp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_message_end,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_byte_kind,
    output logic [7:0]  o_data_out,
    output logic [31:0] o_arg_index,
    output logic        o_arg_done,
    output logic [2:0]  o_verdict,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);

    logic [31:0] r_max_args;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    t_result     step_result;
    logic        advance;
    logic        step;

    // pipeline movement
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    // argument limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_args <= MAX_ARGS_RESET;
        end else if (i_cfg_we) begin
            r_max_args <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_payload_byte;
            r_in_last <= i_message_end;
        end
    end

    // byte parser
    lprp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_max_args (r_max_args),
        .o_result   (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_byte_kind = r_out.byte_kind;
    assign o_data_out  = r_out.data_out;
    assign o_arg_index = r_out.arg_index;
    assign o_arg_done  = r_out.arg_done;
    assign o_verdict   = r_out.verdict;

endmodule

>>> rtl/core/lprp_parser.sv
module lprp_parser import lprp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [31:0] i_max_args,
    output t_result     o_result
);

    t_phase      r_phase,     n_phase;
    logic [1:0]  r_pos,       n_pos;
    logic [23:0] r_word,      n_word;
    logic [31:0] r_args,      n_args;
    logic [31:0] r_cur,       n_cur;
    logic [31:0] r_remain,    n_remain;
    t_verdict    r_err,       n_err;

    logic [31:0] field_full;
    logic        field_last;
    logic [31:0] cur_inc;
    logic [31:0] remain_dec;

    // field assembly: the current byte goes on top of the three bytes held in the word
    assign field_full = {i_byte, r_word};
    assign field_last = (r_pos == 2'd3);
    assign cur_inc    = r_cur + 32'd1;
    assign remain_dec = r_remain - 32'd1;

    // next state and result for one byte
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_word   = r_word;
        n_args   = r_args;
        n_cur    = r_cur;
        n_remain = r_remain;
        n_err    = r_err;

        o_result.byte_kind = KIND_DISCARD;
        o_result.data_out  = i_byte;
        o_result.arg_index = '0;
        o_result.arg_done  = 1'b0;
        o_result.verdict   = VERD_PENDING;

        // shift the byte into the word being built
        if (r_phase == PH_COUNT || r_phase == PH_LENGTH) begin
            n_pos = r_pos + 2'd1;
            case (r_pos)
                2'd0:    n_word = {16'd0, i_byte};
                2'd1:    n_word = {8'd0, i_byte, r_word[7:0]};
                2'd2:    n_word = {i_byte, r_word[15:0]};
                default: n_word = '0;
            endcase
        end

        case (r_phase)
            PH_COUNT: begin
                o_result.byte_kind = KIND_COUNT;
                if (field_last) begin
                    n_args = field_full;
                    if (field_full > i_max_args) begin
                        n_err   = VERD_TOO_MANY;
                        n_phase = PH_DISCARD;
                    end else if (field_full == 32'd0) begin
                        n_phase = PH_DISCARD;
                    end else begin
                        n_phase = PH_LENGTH;
                    end
                end
            end
            PH_LENGTH: begin
                o_result.byte_kind = KIND_LENGTH;
                o_result.arg_index = r_cur;
                if (field_last) begin
                    n_remain = field_full;
                    if (field_full == 32'd0) begin
                        o_result.arg_done = 1'b1;
                        n_cur   = cur_inc;
                        n_phase = (cur_inc == r_args) ? PH_DISCARD : PH_LENGTH;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                o_result.byte_kind = KIND_DATA;
                o_result.arg_index = r_cur;
                n_remain = remain_dec;
                if (remain_dec == 32'd0) begin
                    o_result.arg_done = 1'b1;
                    n_cur   = cur_inc;
                    n_phase = (cur_inc == r_args) ? PH_DISCARD : PH_LENGTH;
                end
            end
            PH_DISCARD: begin
                if (r_err == VERD_PENDING) begin
                    n_err = VERD_TRAILING;
                end
            end
            default: begin
                n_phase = PH_COUNT;
            end
        endcase

        // verdict on the last byte, then back to a clean parse
        if (i_last) begin
            if (n_err != VERD_PENDING) begin
                o_result.verdict = n_err;
            end else if (n_phase == PH_DISCARD) begin
                o_result.verdict = VERD_ACCEPTED;
            end else begin
                o_result.verdict = VERD_TRUNCATED;
            end
            n_phase  = PH_COUNT;
            n_pos    = '0;
            n_word   = '0;
            n_args   = '0;
            n_cur    = '0;
            n_remain = '0;
            n_err    = VERD_PENDING;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_COUNT;
            r_pos    <= '0;
            r_word   <= '0;
            r_args   <= '0;
            r_cur    <= '0;
            r_remain <= '0;
            r_err    <= VERD_PENDING;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_pos    <= n_pos;
            r_word   <= n_word;
            r_args   <= n_args;
            r_cur    <= n_cur;
            r_remain <= n_remain;
            r_err    <= n_err;
        end
    end

endmodule
